// ===== design/smapwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMA actuator PWM sequencer package
// Shared widths, timing constants, codes and the PWM on-time function.
// ----------------------------------------------------------------------------
package smapwm_pkg;

   localparam int PWM_PERIOD_MS = 50;
   localparam int RECOVERY_MS   = 3000;
   localparam int FULL_SCALE_MA = 1515;
   localparam int HOLD_MAX_MS   = 8000;

   localparam int CUR_W      = 11;
   localparam int RT_W       = 12;
   localparam int HOLD_W     = 13;
   localparam int ELAPSED_W  = 14;
   localparam int INTERVAL_W = 12;
   localparam int ON_W       = $clog2(PWM_PERIOD_MS + 1);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [RT_W-1:0]      RETRACT_TIME_LIMIT = RT_W'(2500);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX        = '1;

   localparam logic [CUR_W-1:0] RETRACT_CURRENT_RESET = CUR_W'(1200);
   localparam logic [CUR_W-1:0] HOLD_CURRENT_RESET    = CUR_W'(700);
   localparam logic [RT_W-1:0]  RETRACT_TIME_RESET    = RT_W'(2000);

   localparam logic [CSR_ADDR_W-1:0] CSR_RETRACT_CURRENT = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_CURRENT    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_RETRACT_TIME    = CSR_ADDR_W'(2);

   // Scaling by PWM_PERIOD_MS / FULL_SCALE_MA is a multiply by a rounded-up
   // reciprocal; the shift is large enough to be exact for every current.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 32;
   localparam longint unsigned RECIP_LL =
      ((longint'(PWM_PERIOD_MS) << RECIP_SHIFT) + longint'(FULL_SCALE_MA) - 1) /
      longint'(FULL_SCALE_MA);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_LL);
   localparam int MUL_W  = CUR_W + RECIP_W;
   localparam int QUOT_W = MUL_W - RECIP_SHIFT;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_RETRACT = 2'd1,
      ACT_EXTEND  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PH_EXTENDED   = 2'd0,
      PH_RETRACTING = 2'd1,
      PH_HOLDING    = 2'd2,
      PH_EXTENDING  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE      = 2'd0,
      EV_RETRACTED = 2'd1,
      EV_EXTENDING = 2'd2,
      EV_EXTENDED  = 2'd3
   } event_type;

   function automatic logic [ON_W-1:0] on_time(input logic [CUR_W-1:0] ma);
      logic [MUL_W-1:0]  prod;
      logic [QUOT_W-1:0] quot;
      logic [ON_W-1:0]   on;
      prod = MUL_W'(ma) * MUL_W'(RECIP);
      quot = prod[MUL_W-1:RECIP_SHIFT];
      if (quot > QUOT_W'(PWM_PERIOD_MS)) begin
         on = ON_W'(PWM_PERIOD_MS);
      end else begin
         on = quot[ON_W-1:0];
      end
      if (on == '0) begin
         on = ON_W'(1);
      end
      return on;
   endfunction

endpackage

// ===== design/sma_actuator_pwm_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMA actuator PWM sequencer
// Runs retract, hold and recovery phases of a shape-memory-alloy actuator
// from millisecond ticks and retract / extend requests.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         tuser: action[1:0]; tdata: hold_ms[12:0]
//  rsp      out        tdata: accepted, drive_on, phase, event_code, power_request
//  csr      in         csr_addr selects register, csr_wdata holds value
//
// For each request the sequencer state and the response are
// computed in the accepting cycle and the response is registered.
// A new request is taken every cycle while the response register is empty or
// being drained. Reset restores the register defaults and the extended phase.
// When rsp_tready is low, the held response blocks further requests.

module sma_actuator_pwm_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // hold_ms[12:0]
   input  logic [1:0]                           req_tuser,  // action[1:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // accepted[0], drive_on[1], phase[3:2], event_code[5:4], power_request[6]
   output logic [7:0]                           rsp_tdata,
   input  logic                                 csr_we,
   input  logic [smapwm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [smapwm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [smapwm_pkg::CUR_W-1:0]      retract_current_ff;
   logic [smapwm_pkg::CUR_W-1:0]      hold_current_ff;
   logic [smapwm_pkg::RT_W-1:0]       retract_time_ff;

   smapwm_pkg::phase_type             phase_ff, phase_in;
   logic [smapwm_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in, elapsed_tick;
   logic [smapwm_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [smapwm_pkg::HOLD_W-1:0]     hold_time_ff, hold_time_in;
   logic [smapwm_pkg::ON_W-1:0]       retract_on_ff, retract_on_in;
   logic [smapwm_pkg::ON_W-1:0]       hold_on_ff, hold_on_in;
   logic                              drive_ff, drive_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_data_ff, rsp_data_in;

   logic                              req_accept;
   smapwm_pkg::action_type            action;
   logic [smapwm_pkg::HOLD_W-1:0]     hold_ms;
   logic [smapwm_pkg::CUR_W-1:0]      hold_limited;
   logic                              accepted;
   smapwm_pkg::event_type             event_code;
   logic [smapwm_pkg::ON_W-1:0]       phase_on, phase_off;
   logic [smapwm_pkg::ELAPSED_W-1:0]  total_time;
   logic [smapwm_pkg::CUR_W-1:0]      csr_current;

   assign action      = smapwm_pkg::action_type'(req_tuser);
   assign hold_ms     = req_tdata[smapwm_pkg::HOLD_W-1:0];
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign csr_current = csr_wdata[smapwm_pkg::CUR_W-1:0];

   assign hold_limited = (hold_current_ff > retract_current_ff) ? retract_current_ff
                                                                : hold_current_ff;
   assign total_time = smapwm_pkg::ELAPSED_W'(retract_time_ff) +
                       smapwm_pkg::ELAPSED_W'(hold_time_ff);

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      interval_in   = interval_ff;
      hold_time_in  = hold_time_ff;
      retract_on_in = retract_on_ff;
      hold_on_in    = hold_on_ff;
      drive_in      = drive_ff;
      accepted      = 1'b0;
      event_code    = smapwm_pkg::EV_NONE;
      elapsed_tick  = elapsed_ff;
      phase_on      = retract_on_ff;
      phase_off     = '0;

      if (req_accept) begin
         case (action)
            smapwm_pkg::ACT_TICK: begin
               if (phase_ff != smapwm_pkg::PH_EXTENDED) begin
                  if ((phase_ff == smapwm_pkg::PH_RETRACTING ||
                       phase_ff == smapwm_pkg::PH_HOLDING) &&
                      elapsed_ff != smapwm_pkg::ELAPSED_MAX) begin
                     elapsed_tick = elapsed_ff + smapwm_pkg::ELAPSED_W'(1);
                  end
                  elapsed_in = elapsed_tick;
                  if (interval_ff > smapwm_pkg::INTERVAL_W'(1)) begin
                     interval_in = interval_ff - smapwm_pkg::INTERVAL_W'(1);
                  end else if (phase_ff == smapwm_pkg::PH_EXTENDING) begin
                     phase_in    = smapwm_pkg::PH_EXTENDED;
                     drive_in    = 1'b0;
                     interval_in = '0;
                     elapsed_in  = '0;
                     event_code  = smapwm_pkg::EV_EXTENDED;
                  end else if (elapsed_tick >= total_time) begin
                     phase_in    = smapwm_pkg::PH_EXTENDING;
                     drive_in    = 1'b0;
                     interval_in = smapwm_pkg::RECOVERY_MS[smapwm_pkg::INTERVAL_W-1:0];
                     event_code  = smapwm_pkg::EV_EXTENDING;
                  end else begin
                     if (elapsed_tick > smapwm_pkg::ELAPSED_W'(retract_time_ff)) begin
                        if (phase_ff == smapwm_pkg::PH_RETRACTING) begin
                           phase_in   = smapwm_pkg::PH_HOLDING;
                           event_code = smapwm_pkg::EV_RETRACTED;
                        end
                        phase_on = hold_on_ff;
                     end
                     phase_off = smapwm_pkg::ON_W'(smapwm_pkg::PWM_PERIOD_MS) - phase_on;
                     if (drive_ff && phase_off != '0) begin
                        interval_in = smapwm_pkg::INTERVAL_W'(phase_off);
                        drive_in    = 1'b0;
                     end else begin
                        interval_in = smapwm_pkg::INTERVAL_W'(phase_on);
                        drive_in    = 1'b1;
                     end
                  end
               end
            end
            smapwm_pkg::ACT_RETRACT: begin
               if (hold_ms <= smapwm_pkg::HOLD_W'(smapwm_pkg::HOLD_MAX_MS) &&
                   phase_ff == smapwm_pkg::PH_EXTENDED) begin
                  accepted      = 1'b1;
                  hold_time_in  = hold_ms;
                  retract_on_in = smapwm_pkg::on_time(retract_current_ff);
                  hold_on_in    = smapwm_pkg::on_time(hold_limited);
                  phase_in      = smapwm_pkg::PH_RETRACTING;
                  elapsed_in    = '0;
                  interval_in   = smapwm_pkg::INTERVAL_W'(retract_on_in);
                  drive_in      = 1'b1;
               end
            end
            smapwm_pkg::ACT_EXTEND: begin
               accepted = 1'b1;
               if (phase_ff == smapwm_pkg::PH_EXTENDED) begin
                  event_code = smapwm_pkg::EV_EXTENDED;
               end else if (phase_ff != smapwm_pkg::PH_EXTENDING) begin
                  phase_in    = smapwm_pkg::PH_EXTENDING;
                  drive_in    = 1'b0;
                  interval_in = smapwm_pkg::RECOVERY_MS[smapwm_pkg::INTERVAL_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_data_in = {1'b0, phase_in != smapwm_pkg::PH_EXTENDED, event_code,
                        phase_in, drive_in, accepted};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retract_current_ff <= smapwm_pkg::RETRACT_CURRENT_RESET;
         hold_current_ff    <= smapwm_pkg::HOLD_CURRENT_RESET;
         retract_time_ff    <= smapwm_pkg::RETRACT_TIME_RESET;
         phase_ff           <= smapwm_pkg::PH_EXTENDED;
         elapsed_ff         <= '0;
         interval_ff        <= '0;
         hold_time_ff       <= '0;
         retract_on_ff      <= '0;
         hold_on_ff         <= '0;
         drive_ff           <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               smapwm_pkg::CSR_RETRACT_CURRENT: begin
                  if (csr_current <= smapwm_pkg::CUR_W'(smapwm_pkg::FULL_SCALE_MA)) begin
                     retract_current_ff <= csr_current;
                  end
               end
               smapwm_pkg::CSR_HOLD_CURRENT: begin
                  hold_current_ff <= csr_current;
               end
               smapwm_pkg::CSR_RETRACT_TIME: begin
                  if (csr_wdata[smapwm_pkg::RT_W-1:0] <= smapwm_pkg::RETRACT_TIME_LIMIT) begin
                     retract_time_ff <= csr_wdata[smapwm_pkg::RT_W-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         interval_ff   <= interval_in;
         hold_time_ff  <= hold_time_in;
         retract_on_ff <= retract_on_in;
         hold_on_ff    <= hold_on_in;
         drive_ff      <= drive_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      !(drive_ff && (phase_ff == smapwm_pkg::PH_EXTENDED ||
                     phase_ff == smapwm_pkg::PH_EXTENDING)))
      else $error("drive is on outside the retract and hold phases");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == smapwm_pkg::PH_EXTENDED |-> interval_ff == '0)
      else $error("interval countdown is running while extended");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == smapwm_pkg::PH_RETRACTING || phase_ff == smapwm_pkg::PH_HOLDING) |->
      (retract_on_ff != '0 && hold_on_ff != '0))
      else $error("zero PWM on-time during an active phase");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && action == smapwm_pkg::ACT_RETRACT &&
       phase_ff == smapwm_pkg::PH_EXTENDED &&
       hold_ms <= smapwm_pkg::HOLD_W'(smapwm_pkg::HOLD_MAX_MS)) |=>
      (phase_ff == smapwm_pkg::PH_RETRACTING && drive_ff))
      else $error("accepted retract request did not start the retract phase");

endmodule

// ===== tb/tb_sma_actuator_pwm_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the SMA actuator PWM sequencer
// Streams tick, retract and extend requests into the sequencer and checks
// every response against an in-bench model of the phase, PWM and recovery
// timing. One retract runs through its PWM phases into recovery, with random
// requests afterwards and random idle gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_sma_actuator_pwm_sequencer;

   localparam int         MAX_GAP      = 12;
   localparam int         STALL_LIMIT  = 1000;
   localparam int         PHASE_TICKS  = 110;
   localparam int         RANDOM_ITEMS = 370;
   localparam int         HOLD_FIELD   = (1 << smapwm_pkg::HOLD_W) - 1;
   localparam int         CUR_FIELD    = (1 << smapwm_pkg::CUR_W) - 1;
   localparam int         RT_FIELD     = (1 << smapwm_pkg::RT_W) - 1;
   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam logic [smapwm_pkg::CSR_ADDR_W-1:0] CSR_UNUSED =
      smapwm_pkg::CSR_ADDR_W'(3);

   typedef struct packed {
      logic                  power_request;
      smapwm_pkg::event_type evt;
      smapwm_pkg::phase_type phase;
      logic                  drive_on;
      logic                  accepted;
   } rsp_fields_type;

   class pwm_sequence_scoreboard_type;
      logic [smapwm_pkg::CUR_W-1:0]      retract_ma;
      logic [smapwm_pkg::CUR_W-1:0]      hold_ma;
      logic [smapwm_pkg::RT_W-1:0]       retract_ms;
      smapwm_pkg::phase_type             phase_now;
      logic [smapwm_pkg::ELAPSED_W-1:0]  elapsed;
      logic [smapwm_pkg::INTERVAL_W-1:0] countdown;
      logic [smapwm_pkg::HOLD_W-1:0]     hold_len;
      logic [smapwm_pkg::ON_W-1:0]       retract_on;
      logic [smapwm_pkg::ON_W-1:0]       hold_on;
      logic                              drive;
      rsp_fields_type                    expected_q[$];
      int                                errors;

      function new();
         retract_ma = smapwm_pkg::RETRACT_CURRENT_RESET;
         hold_ma    = smapwm_pkg::HOLD_CURRENT_RESET;
         retract_ms = smapwm_pkg::RETRACT_TIME_RESET;
         phase_now  = smapwm_pkg::PH_EXTENDED;
         elapsed    = '0;
         countdown  = '0;
         hold_len   = '0;
         retract_on = '0;
         hold_on    = '0;
         drive      = 1'b0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_register(input logic [smapwm_pkg::CSR_ADDR_W-1:0] addr,
                                   input logic [smapwm_pkg::CSR_DATA_W-1:0] value);
         case (addr)
            smapwm_pkg::CSR_RETRACT_CURRENT: begin
               if (value[smapwm_pkg::CUR_W-1:0] <= smapwm_pkg::FULL_SCALE_MA) begin
                  retract_ma = value[smapwm_pkg::CUR_W-1:0];
               end
            end
            smapwm_pkg::CSR_HOLD_CURRENT: begin
               hold_ma = value[smapwm_pkg::CUR_W-1:0];
            end
            smapwm_pkg::CSR_RETRACT_TIME: begin
               if (value[smapwm_pkg::RT_W-1:0] <= smapwm_pkg::RETRACT_TIME_LIMIT) begin
                  retract_ms = value[smapwm_pkg::RT_W-1:0];
               end
            end
            default: begin
            end
         endcase
      endfunction

      function logic [smapwm_pkg::ON_W-1:0] pwm_on_ms(input logic [smapwm_pkg::CUR_W-1:0] ma);
         int unsigned on;
         on = (int'(ma) * smapwm_pkg::PWM_PERIOD_MS) / smapwm_pkg::FULL_SCALE_MA;
         if (on > smapwm_pkg::PWM_PERIOD_MS) on = smapwm_pkg::PWM_PERIOD_MS;
         if (on == 0) on = 1;
         return smapwm_pkg::ON_W'(on);
      endfunction

      function void start_cooldown();
         phase_now = smapwm_pkg::PH_EXTENDING;
         drive     = 1'b0;
         countdown = smapwm_pkg::INTERVAL_W'(smapwm_pkg::RECOVERY_MS);
      endfunction

      function smapwm_pkg::event_type interval_done();
         smapwm_pkg::event_type        ev;
         logic [smapwm_pkg::ON_W-1:0]  on;
         int unsigned                  off;
         ev = smapwm_pkg::EV_NONE;
         if (phase_now == smapwm_pkg::PH_EXTENDING) begin
            phase_now = smapwm_pkg::PH_EXTENDED;
            drive     = 1'b0;
            countdown = '0;
            elapsed   = '0;
            return smapwm_pkg::EV_EXTENDED;
         end
         if (int'(elapsed) >= int'(retract_ms) + int'(hold_len)) begin
            start_cooldown();
            return smapwm_pkg::EV_EXTENDING;
         end
         if (int'(elapsed) > int'(retract_ms)) begin
            if (phase_now == smapwm_pkg::PH_RETRACTING) begin
               phase_now = smapwm_pkg::PH_HOLDING;
               ev        = smapwm_pkg::EV_RETRACTED;
            end
            on = hold_on;
         end else begin
            on = retract_on;
         end
         off = smapwm_pkg::PWM_PERIOD_MS - on;
         if (drive) begin
            if (off > 0) begin
               countdown = smapwm_pkg::INTERVAL_W'(off);
               drive     = 1'b0;
            end else begin
               countdown = smapwm_pkg::INTERVAL_W'(on);
            end
         end else begin
            countdown = smapwm_pkg::INTERVAL_W'(on);
            drive     = 1'b1;
         end
         return ev;
      endfunction

      function void note_request(input logic [1:0] action,
                                 input logic [smapwm_pkg::HOLD_W-1:0] hold);
         rsp_fields_type               want;
         logic [smapwm_pkg::CUR_W-1:0] hc;
         logic                         acc;
         smapwm_pkg::event_type        ev;
         acc = 1'b0;
         ev  = smapwm_pkg::EV_NONE;
         case (action)
            smapwm_pkg::ACT_TICK: begin
               if (phase_now != smapwm_pkg::PH_EXTENDED) begin
                  if ((phase_now == smapwm_pkg::PH_RETRACTING ||
                       phase_now == smapwm_pkg::PH_HOLDING) &&
                      elapsed != smapwm_pkg::ELAPSED_MAX) begin
                     elapsed = elapsed + smapwm_pkg::ELAPSED_W'(1);
                  end
                  if (countdown > 1) begin
                     countdown = countdown - smapwm_pkg::INTERVAL_W'(1);
                  end else begin
                     countdown = '0;
                     ev        = interval_done();
                  end
               end
            end
            smapwm_pkg::ACT_RETRACT: begin
               if (hold <= smapwm_pkg::HOLD_MAX_MS &&
                   phase_now == smapwm_pkg::PH_EXTENDED) begin
                  hc         = (hold_ma > retract_ma) ? retract_ma : hold_ma;
                  acc        = 1'b1;
                  hold_len   = hold;
                  retract_on = pwm_on_ms(retract_ma);
                  hold_on    = pwm_on_ms(hc);
                  phase_now  = smapwm_pkg::PH_RETRACTING;
                  elapsed    = '0;
                  countdown  = smapwm_pkg::INTERVAL_W'(retract_on);
                  drive      = 1'b1;
               end
            end
            smapwm_pkg::ACT_EXTEND: begin
               acc = 1'b1;
               if (phase_now == smapwm_pkg::PH_EXTENDED) begin
                  ev = smapwm_pkg::EV_EXTENDED;
               end else if (phase_now != smapwm_pkg::PH_EXTENDING) begin
                  start_cooldown();
               end
            end
            default: begin
            end
         endcase
         want.accepted      = acc;
         want.drive_on      = drive;
         want.phase         = phase_now;
         want.evt           = ev;
         want.power_request = (phase_now != smapwm_pkg::PH_EXTENDED);
         expected_q.push_back(want);
      endfunction

      function void compare_field(input string name, input logic [1:0] want,
                                  input logic [1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(input logic [7:0] data);
         rsp_fields_type got;
         rsp_fields_type want;
         got = data[6:0];
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected nothing, got %h",
                     $time, data);
            return;
         end
         want = expected_q.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("drive_on", want.drive_on, got.drive_on);
         compare_field("phase", want.phase, got.phase);
         compare_field("event_code", want.evt, got.evt);
         compare_field("power_request", want.power_request, got.power_request);
      endfunction
   endclass

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata  = '0;  // hold_ms[12:0]
   logic [1:0]                        req_tuser  = '0;  // action[1:0]
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // accepted[0], drive_on[1], phase[3:2], event_code[5:4], power_request[6]
   logic [7:0]                        rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [smapwm_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [smapwm_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   bit                          req_quiet = 1'b0;
   bit                          rsp_quiet = 1'b0;
   int                          idle_cycles = 0;
   pwm_sequence_scoreboard_type sb;

   sma_actuator_pwm_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_register(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata[smapwm_pkg::HOLD_W-1:0]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_sma_actuator_pwm_sequencer: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap(inout bit quiet_flag);
      if ($urandom_range(0, 99) == 0) quiet_flag = ($urandom_range(0, 2) != 0);
      return quiet_flag ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [smapwm_pkg::HOLD_W-1:0] pick_hold();
      case ($urandom_range(0, 9))
         0: return smapwm_pkg::HOLD_W'($urandom_range(smapwm_pkg::HOLD_MAX_MS + 1,
                                                      HOLD_FIELD));
         1: return smapwm_pkg::HOLD_W'($urandom_range(0, smapwm_pkg::HOLD_MAX_MS));
         default: return smapwm_pkg::HOLD_W'($urandom_range(0, 300));
      endcase
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic send_request(input logic [1:0] action,
                               input logic [smapwm_pkg::HOLD_W-1:0] hold);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {3'b000, hold};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [smapwm_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [smapwm_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic configure(input int r_ma, input int h_ma, input int r_ms);
      wait_idle();
      write_csr(smapwm_pkg::CSR_RETRACT_CURRENT, smapwm_pkg::CSR_DATA_W'(r_ma));
      write_csr(smapwm_pkg::CSR_HOLD_CURRENT, smapwm_pkg::CSR_DATA_W'(h_ma));
      write_csr(smapwm_pkg::CSR_RETRACT_TIME, smapwm_pkg::CSR_DATA_W'(r_ms));
      write_csr(CSR_UNUSED, smapwm_pkg::CSR_DATA_W'($urandom_range(0, RT_FIELD)));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = draw_gap(rsp_quiet);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      logic [1:0] action;
      sb = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_request(smapwm_pkg::ACT_TICK, '0);
      send_request(ACT_UNUSED, smapwm_pkg::HOLD_W'(HOLD_FIELD));
      send_request(smapwm_pkg::ACT_EXTEND, smapwm_pkg::HOLD_W'(13'h1555));
      send_request(smapwm_pkg::ACT_RETRACT, smapwm_pkg::HOLD_W'(smapwm_pkg::HOLD_MAX_MS + 1));
      send_request(smapwm_pkg::ACT_RETRACT, smapwm_pkg::HOLD_W'(HOLD_FIELD));
      repeat (3) send_request(smapwm_pkg::ACT_TICK, smapwm_pkg::HOLD_W'(13'h0aaa));
      send_request(smapwm_pkg::ACT_EXTEND, '0);

      // Out-of-range retract current and retract time writes are dropped by the block.
      configure(smapwm_pkg::FULL_SCALE_MA + 1, CUR_FIELD,
                int'(smapwm_pkg::RETRACT_TIME_LIMIT) + 1);
      // Hold current above retract current is limited to the retract current.
      configure(1000, CUR_FIELD, 40);
      send_request(smapwm_pkg::ACT_RETRACT, smapwm_pkg::HOLD_W'(60));
      send_request(smapwm_pkg::ACT_RETRACT, '0);
      repeat (PHASE_TICKS) begin
         send_request(smapwm_pkg::ACT_TICK, smapwm_pkg::HOLD_W'($urandom_range(0, HOLD_FIELD)));
      end
      send_request(smapwm_pkg::ACT_EXTEND, '0);
      send_request(smapwm_pkg::ACT_EXTEND, '0);

      repeat (RANDOM_ITEMS) begin
         action = 2'($urandom_range(0, 3));
         send_request(action, (action == smapwm_pkg::ACT_RETRACT) ? pick_hold()
                              : smapwm_pkg::HOLD_W'($urandom_range(0, HOLD_FIELD)));
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("tb_sma_actuator_pwm_sequencer: clean");
      end else begin
         $display("tb_sma_actuator_pwm_sequencer: errors");
      end
      $finish;
   end

endmodule
